[rtl/core/esd_pkg.sv]
// esd_pkg: shared types and constants for the escape sequence string decoder
// transfer payload structs and the decoded length bound; no dependencies
`timescale 1ns / 1ps
package esd_pkg;

  localparam int unsigned MAX_LENGTH = 4096;
  localparam int unsigned LEN_W      = 13;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             out_last;
    logic [LEN_W-1:0] out_length;
  } out_item_t;

endpackage

[rtl/core/escape_sequence_string_decoder.sv]
// escape_sequence_string_decoder: streaming backslash, caret and key-prefix decoder
// an input transfer passes the input register and then the result register
// throughput: 1 input byte per cycle while the result register can load; a byte
//   that yields k results holds it until all k are taken (k is at most 3)
// reset: rst_ni clears the input valid flag and the result count and puts the decoder
//   in plain text mode; all decode state also returns there after a last byte
// depends on esd_pkg
`timescale 1ns / 1ps
module escape_sequence_string_decoder
  import esd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam logic [2:0] MODE_PLAIN     = 3'd0;
  localparam logic [2:0] MODE_HELD_M    = 3'd1;
  localparam logic [2:0] MODE_HELD_C    = 3'd2;
  localparam logic [2:0] MODE_BACKSLASH = 3'd3;
  localparam logic [2:0] MODE_CTRL      = 3'd4;
  localparam logic [2:0] MODE_OCTAL     = 3'd5;

  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_CARET = 8'h5e;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_LOW_C = 8'h63;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LENGTH + 1);

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    to_lower = (b inside {[8'h41:8'h5a]}) ? (b + 8'd32) : b;
  endfunction

  function automatic logic [7:0] ctrl_of(input logic [7:0] b);
    ctrl_of = (b == CH_QUEST) ? 8'h7f : {3'b000, b[4:0]};
  endfunction

  function automatic logic [7:0] escape_of(input logic [7:0] b);
    case (to_lower(b))
      8'h6e:   escape_of = 8'h0a;  // n
      8'h72:   escape_of = 8'h0d;  // r
      8'h74:   escape_of = 8'h09;  // t
      8'h62:   escape_of = 8'h08;  // b
      8'h66:   escape_of = 8'h0c;  // f
      8'h61:   escape_of = 8'h07;  // a
      8'h76:   escape_of = 8'h0b;  // v
      8'h65:   escape_of = 8'h1b;  // e
      default: escape_of = b;
    endcase
  endfunction

  // input register
  logic     in_valid_q;
  in_item_t in_q;

  // decode state
  logic [2:0]       mode_q, mode_d;
  logic [7:0]       oct_q, oct_d;
  logic [7:0]       prev_q, prev_d;
  logic [7:0]       held_q, held_d;
  logic [15:0]      ft_q, ft_d;
  logic [7:0]       lo_q, lo_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;

  // result register
  out_item_t  ent_q [3];
  out_item_t  ent_d [3];
  logic [1:0] res_cnt_q;
  logic [1:0] total;

  logic advance, xfer, load_ok;

  // plain text handling of the current byte
  logic       pl_emit;
  logic [2:0] pl_mode;
  logic [7:0] pl_held;

  logic [7:0] b;
  logic       lst;

  assign b   = in_q.in_byte;
  assign lst = in_q.in_last;

  always_comb begin
    logic eligible;
    eligible = (prev_q <= CH_SPACE) || (prev_q >= 8'h7f);
    pl_emit  = 1'b0;
    pl_mode  = MODE_PLAIN;
    pl_held  = held_q;
    if (b == CH_BSL) begin
      if (!lst) pl_mode = MODE_BACKSLASH;
    end else if (b == CH_CARET) begin
      if (!lst) pl_mode = MODE_CTRL;
    end else if ((to_lower(b) == 8'h6d) && !lst && eligible) begin
      pl_held = b;
      pl_mode = MODE_HELD_M;
    end else if ((to_lower(b) == CH_LOW_C) && !lst) begin
      pl_held = b;
      pl_mode = MODE_HELD_C;
    end else begin
      pl_emit = 1'b1;
    end
  end

  // main decode: up to two bytes, then the terminal suffix
  logic [7:0] mv [2];
  logic [1:0] mn;

  always_comb begin
    logic       is_dig;
    logic [7:0] oct_new;
    is_dig  = b inside {[8'h30:8'h37]};
    oct_new = {oct_q[4:0], b[2:0]};
    mode_d  = MODE_PLAIN;
    oct_d   = oct_q;
    prev_d  = b;
    held_d  = held_q;
    mv[0]   = b;
    mv[1]   = b;
    mn      = 2'd0;
    case (mode_q)
      MODE_HELD_M: begin
        if (b == CH_DASH) begin
          mv[0]  = CH_ESC;
          mn     = 2'd1;
          prev_d = CH_LOW_E;
        end else begin
          mv[0]  = held_q;
          mn     = pl_emit ? 2'd2 : 2'd1;
          mode_d = pl_mode;
          held_d = pl_held;
        end
      end
      MODE_HELD_C: begin
        if (b == CH_DASH) begin
          if (!lst) mode_d = MODE_CTRL;
        end else begin
          mv[0]  = held_q;
          mn     = pl_emit ? 2'd2 : 2'd1;
          mode_d = pl_mode;
          held_d = pl_held;
        end
      end
      MODE_BACKSLASH: begin
        if (is_dig) begin
          oct_d = {5'b00000, b[2:0]};
          if (lst) begin
            mv[0] = {5'b00000, b[2:0]};
            mn    = 2'd1;
          end else begin
            mode_d = MODE_OCTAL;
          end
        end else if (to_lower(b) == CH_LOW_C) begin
          if (!lst) mode_d = MODE_CTRL;
        end else begin
          mv[0] = escape_of(b);
          mn    = 2'd1;
        end
      end
      MODE_CTRL: begin
        mv[0] = ctrl_of(b);
        mn    = 2'd1;
      end
      MODE_OCTAL: begin
        if (is_dig) begin
          oct_d  = oct_new;
          mode_d = MODE_OCTAL;
          if (lst) begin
            mv[0] = oct_new;
            mn    = 2'd1;
          end
        end else begin
          mv[0]  = oct_q;
          mn     = pl_emit ? 2'd2 : 2'd1;
          mode_d = pl_mode;
          held_d = pl_held;
        end
      end
      default: begin
        mn     = pl_emit ? 2'd1 : 2'd0;
        mode_d = pl_mode;
        held_d = pl_held;
      end
    endcase
  end

  // running count, first two bytes and last byte through each emitted byte
  always_comb begin
    logic             app;
    logic [7:0]       abyte;
    logic [7:0]       second;
    logic [LEN_W-1:0] len [3];
    logic [7:0]       val [3];
    ft_d   = ft_q;
    cnt_d  = cnt_q;
    lo_d   = lo_q;
    app    = 1'b0;
    abyte  = CH_CR;
    val[0] = mv[0];
    val[1] = mv[1];
    val[2] = 8'h00;
    for (int i = 0; i < 3; i++) len[i] = cnt_q;
    for (int i = 0; i < 2; i++) begin
      if (2'(i) < mn) begin
        if (cnt_d == '0) ft_d = {8'h00, mv[i]};
        else if (cnt_d == LEN_W'(1)) ft_d[15:8] = mv[i];
        if (cnt_d < LEN_MAX) cnt_d = cnt_d + LEN_W'(1);
        lo_d   = mv[i];
        len[i] = cnt_d;
      end
    end
    second = ft_d[15:8];
    if (lst && (cnt_d >= LEN_W'(2)) && (ft_d[7:0] == CH_ESC)) begin
      if (to_lower(second) == 8'h78) begin
        app   = (lo_d != CH_CR);
        abyte = CH_CR;
      end else if (second == CH_RBRK) begin
        app   = (lo_d != CH_BEL);
        abyte = CH_BEL;
      end
    end
    if (app) begin
      if (cnt_d < LEN_MAX) cnt_d = cnt_d + LEN_W'(1);
      lo_d = abyte;
      val[mn] = abyte;
      len[mn] = cnt_d;
    end
    total = mn + {1'b0, app};
    for (int i = 0; i < 3; i++) begin
      ent_d[i].out_byte   = val[i];
      ent_d[i].out_last   = 1'b0;
      ent_d[i].out_length = len[i];
    end
    // empty final step still reports the length
    if (lst && (total == 2'd0)) begin
      ent_d[0].out_byte   = 8'h00;
      ent_d[0].out_length = cnt_d;
      total = 2'd1;
    end
    if (lst) ent_d[total - 2'd1].out_last = 1'b1;
  end

  assign out_valid_o = (res_cnt_q != 2'd0);
  assign out_data_o  = ent_q[0];
  assign xfer        = out_valid_o && !out_stall_i;
  assign load_ok     = (res_cnt_q == 2'd0) || ((res_cnt_q == 2'd1) && xfer);
  assign advance     = in_valid_q && load_ok;
  assign in_stall_o  = in_valid_q && !load_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      oct_q  <= 8'h00;
      prev_q <= CH_SPACE;
      held_q <= 8'h00;
      ft_q   <= 16'h0000;
      lo_q   <= 8'h00;
      cnt_q  <= '0;
    end else if (advance) begin
      if (lst) begin
        // string done, back to the start-of-string state
        mode_q <= MODE_PLAIN;
        oct_q  <= 8'h00;
        prev_q <= CH_SPACE;
        held_q <= 8'h00;
        ft_q   <= 16'h0000;
        lo_q   <= 8'h00;
        cnt_q  <= '0;
      end else begin
        mode_q <= mode_d;
        oct_q  <= oct_d;
        prev_q <= prev_d;
        held_q <= held_d;
        ft_q   <= ft_d;
        lo_q   <= lo_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cnt_q <= 2'd0;
    end else if (advance && (total != 2'd0)) begin
      res_cnt_q <= total;
    end else if (xfer) begin
      res_cnt_q <= res_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && (total != 2'd0)) begin
      for (int i = 0; i < 3; i++) ent_q[i] <= ent_d[i];
    end else if (xfer) begin
      ent_q[0] <= ent_q[1];
      ent_q[1] <= ent_q[2];
    end
  end

endmodule

[sim/tb.sv]
// tb: self-checking testbench for escape_sequence_string_decoder
// random and directed strings go in, decoded bytes are checked against a
// scoreboard that decodes the same raw stream; depends on esd_pkg and the rtl
`timescale 1ns / 1ps
module tb;
  import esd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 430;
  localparam int QUIET_FROM = 360;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam string ESC_LETTERS = "nrtbfaveNRTBFAVE";

  typedef enum logic [2:0] {
    MODE_PLAIN,
    MODE_HELD_M,
    MODE_HELD_C,
    MODE_BACKSLASH,
    MODE_CTRL,
    MODE_OCTAL
  } decode_mode_e;

  class decoder_scoreboard;
    decode_mode_e mode;
    logic [7:0] octal_acc;
    logic [7:0] prev_raw;
    logic [7:0] held_raw;
    logic [7:0] first_out;
    logic [7:0] second_out;
    logic [7:0] last_byte_out;
    int unsigned decoded_len;
    int errors;
    out_item_t step_results[$];
    out_item_t pending_decoded[$];

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      mode = MODE_PLAIN;
      octal_acc = 8'h00;
      prev_raw = CH_SPACE;
      held_raw = 8'h00;
      first_out = 8'h00;
      second_out = 8'h00;
      last_byte_out = 8'h00;
      decoded_len = 0;
    endfunction

    function void put_decoded(logic [7:0] b);
      out_item_t r;
      if (decoded_len == 0) first_out = b;
      else if (decoded_len == 1) second_out = b;
      if (decoded_len < MAX_LENGTH + 1) decoded_len++;
      last_byte_out = b;
      r.out_byte = b;
      r.out_last = 1'b0;
      r.out_length = decoded_len[LEN_W-1:0];
      step_results.push_back(r);
    endfunction

    function logic [7:0] lower_of(logic [7:0] b);
      return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    endfunction

    function logic [7:0] escape_value(logic [7:0] b);
      case (lower_of(b))
        "n": return 8'd10;
        "r": return 8'd13;
        "t": return 8'd9;
        "b": return 8'd8;
        "f": return 8'd12;
        "a": return 8'd7;
        "v": return 8'd11;
        "e": return 8'd27;
        default: return b;
      endcase
    endfunction

    function void plain_char(logic [7:0] b, logic last);
      logic eligible;
      eligible = (prev_raw <= CH_SPACE) || (prev_raw >= CH_DEL);
      if (b == CH_BSLASH) begin
        if (!last) mode = MODE_BACKSLASH;
      end else if (b == CH_CARET) begin
        if (!last) mode = MODE_CTRL;
      end else if ((b == "m" || b == "M") && !last && eligible) begin
        held_raw = b;
        mode = MODE_HELD_M;
      end else if ((b == "c" || b == "C") && !last) begin
        held_raw = b;
        mode = MODE_HELD_C;
      end else begin
        put_decoded(b);
      end
      prev_raw = b;
    endfunction

    function void note_raw_byte(logic [7:0] b, logic last);
      logic is_octal;
      is_octal = (b >= "0" && b <= "7");
      step_results.delete();
      case (mode)
        MODE_HELD_M: begin
          mode = MODE_PLAIN;
          if (b == CH_DASH) begin
            put_decoded(CH_ESC);
            prev_raw = "e";
          end else begin
            put_decoded(held_raw);
            plain_char(b, last);
          end
        end
        MODE_HELD_C: begin
          mode = MODE_PLAIN;
          if (b == CH_DASH) begin
            if (!last) mode = MODE_CTRL;
            prev_raw = b;
          end else begin
            put_decoded(held_raw);
            plain_char(b, last);
          end
        end
        MODE_BACKSLASH: begin
          mode = MODE_PLAIN;
          if (is_octal) begin
            octal_acc = {5'b0, b[2:0]};
            if (last) put_decoded(octal_acc);
            else mode = MODE_OCTAL;
          end else if (lower_of(b) == "c") begin
            if (!last) mode = MODE_CTRL;
          end else begin
            put_decoded(escape_value(b));
          end
          prev_raw = b;
        end
        MODE_CTRL: begin
          mode = MODE_PLAIN;
          put_decoded((b == CH_QMARK) ? CH_DEL : (b & 8'h1F));
          prev_raw = b;
        end
        MODE_OCTAL: begin
          if (is_octal) begin
            // eight bits only, so long runs wrap
            octal_acc = {octal_acc[4:0], 3'b000} + {5'b0, b[2:0]};
            if (last) put_decoded(octal_acc);
            prev_raw = b;
          end else begin
            mode = MODE_PLAIN;
            put_decoded(octal_acc);
            plain_char(b, last);
          end
        end
        default: begin
          mode = MODE_PLAIN;
          plain_char(b, last);
        end
      endcase
      if (last) begin
        // terminal strings get their closing CR or BEL
        if (decoded_len >= 2 && first_out == CH_ESC) begin
          if (second_out == "x" || second_out == "X") begin
            if (last_byte_out != CH_CR) put_decoded(CH_CR);
          end else if (second_out == CH_RBRACKET) begin
            if (last_byte_out != CH_BEL) put_decoded(CH_BEL);
          end
        end
        if (step_results.size() == 0) begin
          out_item_t r;
          r.out_byte = 8'h00;
          r.out_last = 1'b1;
          r.out_length = decoded_len[LEN_W-1:0];
          step_results.push_back(r);
        end else begin
          step_results[step_results.size()-1].out_last = 1'b1;
        end
        clear_state();
      end
      foreach (step_results[i]) pending_decoded.push_back(step_results[i]);
    endfunction

    function void check_decoded(out_item_t got);
      out_item_t want;
      if (pending_decoded.size() == 0) begin
        $display("%0t: unexpected transfer, expected none actual %02h/%0d/%0d", $time,
                 got.out_byte, got.out_last, got.out_length);
        errors++;
        return;
      end
      want = pending_decoded.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want.out_byte,
                 got.out_byte);
        errors++;
      end
      if (got.out_last !== want.out_last) begin
        $display("%0t: out_last expected %0d actual %0d", $time, want.out_last,
                 got.out_last);
        errors++;
      end
      if (got.out_length !== want.out_length) begin
        $display("%0t: out_length expected %0d actual %0d", $time, want.out_length,
                 got.out_length);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;

  decoder_scoreboard board = new();
  logic [7:0] raw_q[$];
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int raw_sent = 0;
  int cycles = 0;

  escape_sequence_string_decoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("escape_sequence_string_decoder verification failed");
      $finish;
    end
  end

  // receiver stalls in bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_decoded(out_data_o);
  end

  task automatic push_raw(input logic [7:0] b, input logic last);
    in_item_t item;
    item.in_byte = b;
    item.in_last = last;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    board.note_raw_byte(b, last);
    raw_sent++;
  endtask

  task automatic send_raw_q();
    foreach (raw_q[i]) push_raw(raw_q[i], i == raw_q.size() - 1);
  endtask

  function automatic void append_text(string s);
    for (int i = 0; i < s.len(); i++) raw_q.push_back(s[i]);
  endfunction

  task automatic send_text(string s);
    raw_q.delete();
    append_text(s);
    send_raw_q();
  endtask

  function automatic void add_token();
    int n;
    case ($urandom_range(0, 11))
      0, 1: raw_q.push_back(8'($urandom_range(33, 126)));
      2: raw_q.push_back(8'($urandom_range(0, 255)));
      3: raw_q.push_back(CH_SPACE);
      4: begin
        raw_q.push_back(CH_BSLASH);
        raw_q.push_back(ESC_LETTERS[$urandom_range(0, 15)]);
      end
      5: begin
        raw_q.push_back(CH_BSLASH);
        raw_q.push_back(8'($urandom_range(0, 255)));
      end
      6: begin
        raw_q.push_back(CH_BSLASH);
        n = $urandom_range(1, 4);
        repeat (n) raw_q.push_back(8'($urandom_range(48, 55)));
      end
      7: begin
        raw_q.push_back(CH_CARET);
        raw_q.push_back($urandom_range(0, 3) == 0 ? CH_QMARK : 8'($urandom_range(0, 255)));
      end
      8: begin
        // c-X and \cX forms
        if ($urandom_range(0, 1)) begin
          raw_q.push_back($urandom_range(0, 1) ? "c" : "C");
          raw_q.push_back(CH_DASH);
        end else begin
          raw_q.push_back(CH_BSLASH);
          raw_q.push_back($urandom_range(0, 1) ? "c" : "C");
        end
        raw_q.push_back(8'($urandom_range(32, 127)));
      end
      9: begin
        raw_q.push_back($urandom_range(0, 1) ? "m" : "M");
        raw_q.push_back(CH_DASH);
      end
      10: begin
        case ($urandom_range(0, 3))
          0: raw_q.push_back("m");
          1: raw_q.push_back("M");
          2: raw_q.push_back("c");
          default: raw_q.push_back("C");
        endcase
        raw_q.push_back(8'($urandom_range(33, 126)));
      end
      default: raw_q.push_back(8'($urandom_range(48, 57)));
    endcase
  endfunction

  task automatic send_random_string();
    raw_q.delete();
    case ($urandom_range(0, 7))
      0: append_text($urandom_range(0, 1) ? "m-x" : "M-X");
      1: append_text("\\e]");
      2: append_text("^[x");
      3: append_text("M-]");
      default: ;
    endcase
    repeat ($urandom_range(0, 10)) add_token();
    case ($urandom_range(0, 5))
      0: append_text("\\r");
      1: append_text("^G");
      default: ;
    endcase
    // broken endings: drop the final byte now and then
    if (raw_q.size() > 1 && $urandom_range(0, 5) == 0) void'(raw_q.pop_back());
    if (raw_q.size() == 0) raw_q.push_back(8'($urandom_range(0, 255)));
    send_raw_q();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes of the byte field, zero as data
    push_raw(8'h00, 1'b0);
    push_raw(8'hFF, 1'b1);
    send_text("\\");
    send_text("\\777A");
    send_text("m-x^?");
    send_text("M-]\\a");
    send_text("c-");
    send_text("\\12");

    while (raw_sent < RANDOM_ITEMS) begin
      if (raw_sent >= QUIET_FROM) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: gap_pct = 0;
          1: gap_pct = 15;
          default: gap_pct = 40;
        endcase
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      send_random_string();
    end

    in_valid_i <= 1'b0;
    while (board.pending_decoded.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("escape_sequence_string_decoder verification clean");
    end else begin
      $display("escape_sequence_string_decoder verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/esd_pkg.sv
rtl/core/escape_sequence_string_decoder.sv
sim/tb.sv
